@@ rtl/shh_pkg.sv @@
`timescale 1ns / 1ps

package shh_pkg;

  // Table points held in configuration registers.
  localparam int CFG_POINTS = 6;
  localparam int DEF_POINTS = 6;

  localparam int SPEED_W = 16;
  localparam int BP_W    = 16;
  localparam int BYTE_W  = 8;
  localparam int FRAC_W  = 16;
  localparam int SUB_W   = BP_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [SPEED_W-1:0] HIGH_TH_RST = SPEED_W'(500);
  localparam logic [SPEED_W-1:0] LOW_TH_RST  = SPEED_W'(300);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BP_0_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BP_2_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BP_4_5  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES   = 3'd5;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] value;
  } lk_rsp_t;

endpackage

@@ rtl/shh_sub.sv @@
`timescale 1ns / 1ps

// Shared subtractor: compare, difference and divide step all go through here.
module shh_sub (
  input  logic signed [shh_pkg::SUB_W-1:0] a,
  input  logic signed [shh_pkg::SUB_W-1:0] b,
  output logic signed [shh_pkg::SUB_W-1:0] diff,
  output logic                             neg
);
  import shh_pkg::*;

  assign diff = a - b;
  assign neg  = diff[SUB_W-1];

endmodule

@@ rtl/shh_lookup.sv @@
`timescale 1ns / 1ps

// Interpolated table lookup, clamped at both ends: downward search, restoring divide, one multiply.
module shh_lookup #(
  parameter int POINTS = shh_pkg::DEF_POINTS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [shh_pkg::BP_W-1:0]      x,
  input  logic signed [shh_pkg::BP_W-1:0]      bp     [POINTS],
  input  logic        [shh_pkg::BYTE_W-1:0]    tbytes [POINTS],
  output shh_pkg::lk_rsp_t                     rsp
);
  import shh_pkg::*;

  localparam int IDX_W = $clog2(POINTS);
  localparam int CNT_W = $clog2(FRAC_W);
  localparam logic [IDX_W-1:0] TOP      = IDX_W'(POINTS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_W - 1);
  localparam int PROD_W = FRAC_W + BYTE_W + 3;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DEN, S_DIV, S_MUL, S_SUM
  } state_t;

  state_t                    state;
  logic [IDX_W-1:0]          idx;
  logic signed [BP_W-1:0]    x_q;
  logic signed [BP_W-1:0]    bp_lo;
  logic signed [BP_W-1:0]    bp_hi;
  logic [BYTE_W-1:0]         byte_lo;
  logic [BYTE_W-1:0]         byte_hi;
  logic [FRAC_W-1:0]         rem;
  logic [FRAC_W-1:0]         den;
  logic [FRAC_W-1:0]         quo;
  logic [CNT_W-1:0]          cnt;
  logic signed [PROD_W-1:0]  prod;

  logic signed [SUB_W-1:0]   op_a;
  logic signed [SUB_W-1:0]   op_b;
  logic signed [SUB_W-1:0]   diff;
  logic                      neg;
  logic [FRAC_W:0]           rem2;
  logic signed [BYTE_W+1:0]  bdiff;
  logic signed [PROD_W-1:0]  acc;

  assign rem2  = {rem, 1'b0};
  assign bdiff = $signed({2'b00, byte_hi}) - $signed({2'b00, byte_lo});
  assign acc   = $signed({3'b000, byte_lo, {FRAC_W{1'b0}}}) + prod;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state)
      S_SEARCH: begin
        op_a = SUB_W'(x_q);
        op_b = SUB_W'(bp[idx]);
      end
      S_DEN: begin
        op_a = SUB_W'(bp_hi);
        op_b = SUB_W'(bp_lo);
      end
      S_DIV: begin
        op_a = $signed({1'b0, rem2});
        op_b = $signed({2'b00, den});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  shh_sub u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .neg  (neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            idx   <= TOP;
            x_q   <= x;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // shift window: after the hit, lo holds entry i and hi entry i+1
          bp_lo   <= bp[idx];
          bp_hi   <= bp_lo;
          byte_lo <= tbytes[idx];
          byte_hi <= byte_lo;
          if (!neg) begin
            if (idx == TOP) begin
              rsp.value <= tbytes[idx];
              rsp.done  <= 1'b1;
              state     <= S_IDLE;
            end else begin
              rem   <= diff[FRAC_W-1:0];
              state <= S_DEN;
            end
          end else if (idx == '0) begin
            rsp.value <= tbytes[idx];
            rsp.done  <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_DEN: begin
          den   <= diff[FRAC_W-1:0];
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= neg ? rem2[FRAC_W-1:0] : diff[FRAC_W-1:0];
          quo <= {quo[FRAC_W-2:0], ~neg};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'($signed({1'b0, quo})) * PROD_W'(bdiff);
          state <= S_SUM;
        end
        S_SUM: begin
          rsp.value <= acc[FRAC_W+BYTE_W-1:FRAC_W];
          rsp.done  <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/speed_hysteresis_with_holdoff.sv @@
`timescale 1ns / 1ps
// Without a holdoff reload a beat goes through T_DELIVER into the output register.
// With a reload on rising entry the lookup unit runs first: at or above the top breakpoint
// or below every breakpoint it returns the end byte after its search, else s = 2..POINTS
// search steps come before a 16-step restoring divide in the lookup's shared subtractor.
// One item at a time: in_stall is high while an item is worked.
// Reset (rst, synchronous): holdoff 0, band 0, thresholds 500/300, table cleared.
module speed_hysteresis_with_holdoff #(
  parameter int POINTS = shh_pkg::DEF_POINTS
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [shh_pkg::SPEED_W-1:0]        engine_speed,
  input  logic signed [shh_pkg::BP_W-1:0]    lookup_input,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               qualified_flag,
  output logic                               band_flag,
  output logic [shh_pkg::BYTE_W-1:0]         holdoff_count,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [shh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shh_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import shh_pkg::*;

  // T_IDLE takes a beat, T_LOOK waits on the table unit,
  // T_DELIVER holds the result until the output register frees up.
  typedef enum logic [1:0] {
    T_IDLE, T_LOOK, T_DELIVER
  } state_t;

  state_t              state;
  logic [SPEED_W-1:0]  high_th;
  logic [SPEED_W-1:0]  low_th;
  logic signed [BP_W-1:0] bp_cfg   [CFG_POINTS];
  logic [BYTE_W-1:0]      byte_cfg [CFG_POINTS];

  logic [BYTE_W-1:0]   holdoff;
  logic                band;
  logic [BYTE_W-1:0]   hold_q;
  logic                band_q;

  logic signed [BP_W-1:0] bp_pt   [POINTS];
  logic [BYTE_W-1:0]      byte_pt [POINTS];

  logic                in_beat;
  logic                at_high;
  logic                below_low;
  logic                band_new;
  logic                rise;
  logic [BYTE_W-1:0]   hold_dec;
  logic                lk_start;
  lk_rsp_t             lk_rsp;
  logic                deliver;
  logic                cfg_wr;

  // Table points past the register set read as zero.
  for (genvar k = 0; k < POINTS; k++) begin : g_pt
    if (k < CFG_POINTS) begin : g_cfg
      assign bp_pt[k]   = bp_cfg[k];
      assign byte_pt[k] = byte_cfg[k];
    end else begin : g_zero
      assign bp_pt[k]   = '0;
      assign byte_pt[k] = '0;
    end
  end

  assign in_stall  = (state != T_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Hysteresis: high test wins if thresholds are crossed.
  assign at_high   = (engine_speed >= high_th);
  assign below_low = (engine_speed < low_th);
  assign band_new  = at_high ? 1'b1 : (below_low ? 1'b0 : band);
  assign rise      = at_high && !band;
  assign hold_dec  = (holdoff != '0) ? holdoff - 1'b1 : holdoff;
  assign lk_start  = in_beat && rise;

  // Result moves into the output register once it is empty or being drained.
  assign deliver = (state == T_DELIVER) && (!out_valid || !out_stall);

  shh_lookup #(
    .POINTS (POINTS)
  ) u_lookup (
    .clk    (clk),
    .rst    (rst),
    .start  (lk_start),
    .x      (lookup_input),
    .bp     (bp_pt),
    .tbytes (byte_pt),
    .rsp    (lk_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_th <= HIGH_TH_RST;
      low_th  <= LOW_TH_RST;
      for (int k = 0; k < CFG_POINTS; k++) begin
        bp_cfg[k]   <= '0;
        byte_cfg[k] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_HIGH_TH: high_th <= cfg_data[SPEED_W-1:0];
        REG_LOW_TH:  low_th  <= cfg_data[SPEED_W-1:0];
        REG_BP_0_1: begin
          bp_cfg[0] <= cfg_data[15:0];
          bp_cfg[1] <= cfg_data[31:16];
        end
        REG_BP_2_3: begin
          bp_cfg[2] <= cfg_data[15:0];
          bp_cfg[3] <= cfg_data[31:16];
        end
        REG_BP_4_5: begin
          bp_cfg[4] <= cfg_data[15:0];
          bp_cfg[5] <= cfg_data[31:16];
        end
        REG_BYTES: begin
          for (int k = 0; k < CFG_POINTS; k++) begin
            byte_cfg[k] <= cfg_data[k*BYTE_W +: BYTE_W];
          end
        end
        default: ; // unknown index: dropped
      endcase
    end
  end

  // Sequencer, tick state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      holdoff   <= '0;
      band      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_beat) begin
            // decrement first; a reload overwrites it
            hold_q <= hold_dec;
            band_q <= band_new;
            state  <= rise ? T_LOOK : T_DELIVER;
          end
        end
        T_LOOK: begin
          if (lk_rsp.done) begin
            hold_q <= lk_rsp.value;
            state  <= T_DELIVER;
          end
        end
        T_DELIVER: begin
          if (deliver) begin
            holdoff        <= hold_q;
            band           <= band_q;
            qualified_flag <= band_q && (hold_q == '0);
            band_flag      <= band_q;
            holdoff_count  <= hold_q;
            state          <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/shh_check.sv @@
`timescale 1ns / 1ps

module shh_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         qualified_flag,
  input logic                         band_flag,
  input logic [shh_pkg::BYTE_W-1:0]   holdoff_count
);
  import shh_pkg::*;

  // Held output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(qualified_flag)
      && $stable(band_flag) && $stable(holdoff_count))
    else $error("output beat changed while stalled");

  // Qualified flag only with band set and holdoff expired.
  a_qual: assert property (@(posedge clk) disable iff (rst)
    out_valid && qualified_flag |-> band_flag && (holdoff_count == '0))
    else $error("qualified flag set while band clear or holdoff running");

  // One item at a time: input closes right after a beat.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // Output register empty after reset.
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind speed_hysteresis_with_holdoff shh_check u_shh_check (.*);
